// ----- hdl/patu_pkg.sv -----
// Package for the paged address translation unit.
// Holds operation and status codes, mode codes and fixed masks.
// No dependencies; used by the core and by its checker.
package patu_pkg;

  typedef enum logic [1:0] {
    OP_FETCH     = 2'd0,
    OP_DATA      = 2'd1,
    OP_REG_READ  = 2'd2,
    OP_REG_WRITE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NON_RESIDENT = 3'd1,
    ST_LENGTH       = 3'd2,
    ST_READ_ONLY    = 3'd3,
    ST_BUS_ERROR    = 3'd4
  } status_t;

  // Processor modes
  localparam logic [1:0] MODE_KERNEL     = 2'd0;
  localparam logic [1:0] MODE_SUPERVISOR = 2'd1;
  localparam logic [1:0] MODE_ILLEGAL    = 2'd2;
  localparam logic [1:0] MODE_USER       = 2'd3;

  // Configuration register indexes
  localparam logic CFG_MMU_ENABLE = 1'b0;
  localparam logic CFG_DATA_SPACE = 1'b1;

  // Pass-through relocation of the I/O page
  localparam logic [15:0] IO_PAGE  = 16'o170000;
  localparam logic [18:0] IO_RELOC = 19'o600000;

  // Descriptor written bit and fault status abort bits
  localparam logic [15:0] WRITTEN_MASK  = 16'h0040;
  localparam logic [15:0] ABORT_NON_RES = 16'h8000;
  localparam logic [15:0] ABORT_LENGTH  = 16'h4000;
  localparam logic [15:0] ABORT_RD_ONLY = 16'h2000;

endpackage

// ----- hdl/paged_address_translation_unit_core.sv -----
// Paged address translation unit: top level.
// Uses patu_pkg for codes and masks.
//
// Usage:
//   Configuration is written through cfg_write / cfg_index / cfg_data while
//   the unit is idle: index 0 turns translation on, index 1 selects which
//   modes (bit0 user, bit1 supervisor, bit2 kernel) use separate data pages.
//   Each input word on the in_valid/in_ready channel either translates a
//   virtual address (fetch or data access) or reads or writes one page
//   address or page descriptor word. Every input word gives exactly one
//   output word on out_valid/out_ready with the physical address, the abort
//   status, register read data, the fault status word and the fault PC.
//   out_valid rises once a word has passed the input register and then the
//   output register; one word is accepted per cycle unless the receiver
//   stalls. The page tables are two 64-entry memories read at acceptance
//   and written back when the word moves into the output register; a
//   write-to-read bypass keeps back-to-back words on the same page exact.
//   Reset clears the configuration, the fault registers and the per-entry
//   valid bits, so every page word reads as zero until written.
//   When the receiver stalls, the output register holds and the input stage
//   holds its word; in_ready drops only once both are full.
module paged_address_translation_unit_core import patu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [15:0] virtual_address,
  input  logic        is_write,
  input  logic [1:0]  mode,
  input  logic [15:0] current_pc,
  input  logic        reg_space,
  input  logic        reg_kind,
  input  logic [2:0]  reg_page,
  input  logic [15:0] write_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [18:0] physical_address,
  output logic [2:0]  status,
  output logic [15:0] read_data,
  output logic [15:0] status_word,
  output logic [15:0] fault_pc
);

  // Configuration
  logic       mmu_enable;
  logic [2:0] data_space_enable;

  // Input stage
  logic        s1_valid;
  op_t         s1_op;
  logic [15:0] s1_va;
  logic        s1_wr;
  logic [1:0]  s1_mode;
  logic [15:0] s1_pc;
  logic        s1_kind;
  logic [15:0] s1_wval;
  logic [5:0]  s1_idx;

  // Page memories, valid bits and bypass
  logic [15:0] pdr_mem [64];
  logic [15:0] par_mem [64];
  logic [63:0] pdr_vld;
  logic [63:0] par_vld;
  logic [15:0] pdr_rd, par_rd;
  logic        pdr_hit, par_hit;
  logic [15:0] pdr_byp, par_byp;
  logic        pdr_ok, par_ok;
  logic [15:0] pdr_q, par_q;

  // Fault registers
  logic [15:0] fault_status;
  logic [15:0] fault_pc_reg;

  // Output register
  logic [18:0] out_pa;
  status_t     out_st;
  logic [15:0] out_rdata;
  logic [15:0] out_sw;
  logic [15:0] out_fpc;

  // Combinational
  logic        accept;
  logic        s1_adv;
  logic        ds_sel;
  logic        in_is_reg;
  logic [5:0]  rd_idx;
  logic        pdr_we, par_we;
  logic        pdr_wen, par_wen;
  logic [15:0] pdr_wd;
  logic [18:0] pa_next;
  status_t     st_next;
  logic [15:0] rdata_next;
  logic [15:0] fs_next;
  logic [15:0] fpc_next;
  logic [15:0] abort_mask;
  logic        fault;
  logic [6:0]  blk;
  logic [6:0]  len;
  logic [12:0] base_sum;

  // Handshake
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      mmu_enable        <= 1'b0;
      data_space_enable <= 3'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MMU_ENABLE: mmu_enable        <= cfg_data[0];
        CFG_DATA_SPACE: data_space_enable <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pick the data space for a data access in this mode
  always_comb begin
    case (mode)
      MODE_USER:       ds_sel = data_space_enable[0];
      MODE_SUPERVISOR: ds_sel = data_space_enable[1];
      MODE_KERNEL:     ds_sel = data_space_enable[2];
      default:         ds_sel = 1'b1;
    endcase
  end

  // Form the table index of the incoming word
  assign in_is_reg = (operation == OP_REG_READ) || (operation == OP_REG_WRITE);
  assign rd_idx = in_is_reg ? {reg_space, mode, reg_page}
                            : {(operation == OP_DATA) && ds_sel, mode, virtual_address[15:13]};

  // Capture the input word
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op   <= op_t'(operation);
      s1_va   <= virtual_address;
      s1_wr   <= is_write;
      s1_mode <= mode;
      s1_pc   <= current_pc;
      s1_kind <= reg_kind;
      s1_wval <= write_value;
      s1_idx  <= rd_idx;
    end
  end

  // Page memories: write back from the input stage, read at acceptance
  assign pdr_wen = s1_adv && pdr_we;
  assign par_wen = s1_adv && par_we;

  always_ff @(posedge clk) begin
    if (pdr_wen) pdr_mem[s1_idx] <= pdr_wd;
    if (accept)  pdr_rd <= pdr_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (par_wen) par_mem[s1_idx] <= s1_wval;
    if (accept)  par_rd <= par_mem[rd_idx];
  end

  // Mark entries written since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      pdr_vld <= '0;
      par_vld <= '0;
    end else begin
      if (pdr_wen) pdr_vld[s1_idx] <= 1'b1;
      if (par_wen) par_vld[s1_idx] <= 1'b1;
    end
  end

  // Bypass a write-back to the entry being read in the same cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      pdr_hit <= pdr_wen && (s1_idx == rd_idx);
      par_hit <= par_wen && (s1_idx == rd_idx);
      pdr_byp <= pdr_wd;
      par_byp <= s1_wval;
      pdr_ok  <= pdr_vld[rd_idx];
      par_ok  <= par_vld[rd_idx];
    end
  end

  assign pdr_q = pdr_hit ? pdr_byp : (pdr_ok ? pdr_rd : 16'h0000);
  assign par_q = par_hit ? par_byp : (par_ok ? par_rd : 16'h0000);

  // Translate or access the page registers
  assign blk      = s1_va[12:6];
  assign len      = pdr_q[14:8];
  assign base_sum = {6'd0, blk} + {1'b0, par_q[11:0]};

  always_comb begin
    pa_next    = '0;
    st_next    = ST_OK;
    rdata_next = '0;
    pdr_we     = 1'b0;
    par_we     = 1'b0;
    pdr_wd     = pdr_q;
    fault      = 1'b0;
    abort_mask = '0;
    case (s1_op)
      OP_REG_READ, OP_REG_WRITE: begin
        if (s1_mode == MODE_ILLEGAL) begin
          st_next = ST_BUS_ERROR;
        end else if (s1_op == OP_REG_READ) begin
          rdata_next = s1_kind ? par_q : pdr_q;
        end else begin
          pdr_we = 1'b1;
          par_we = s1_kind;
          pdr_wd = (s1_kind ? pdr_q : s1_wval) & ~WRITTEN_MASK;
        end
      end
      default: begin
        if (!mmu_enable) begin
          pa_next = (s1_va >= IO_PAGE) ? {3'b000, s1_va} + IO_RELOC : {3'b000, s1_va};
        end else if (s1_wr && (pdr_q[2:1] != 2'b11)) begin
          st_next    = ST_READ_ONLY;
          fault      = 1'b1;
          abort_mask = ABORT_RD_ONLY;
        end else if (!pdr_q[1]) begin
          st_next    = ST_NON_RESIDENT;
          fault      = 1'b1;
          abort_mask = ABORT_NON_RES;
        end else if ((pdr_q[3] && (blk < len)) || (!pdr_q[3] && (blk > len))) begin
          st_next    = ST_LENGTH;
          fault      = 1'b1;
          abort_mask = ABORT_LENGTH;
        end else begin
          pa_next = {base_sum, s1_va[5:0]};
          if (s1_wr) begin
            pdr_we = 1'b1;
            pdr_wd = pdr_q | WRITTEN_MASK;
          end
        end
      end
    endcase
  end

  // Record a fault: abort bit, page and mode
  always_comb begin
    fs_next  = fault_status;
    fpc_next = fault_pc_reg;
    if (fault) begin
      fs_next      = abort_mask | 16'h0001;
      fs_next[3:1] = s1_va[15:13];
      fs_next[6:5] = s1_mode;
      fpc_next     = s1_pc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fault_status <= '0;
      fault_pc_reg <= '0;
    end else if (s1_adv) begin
      fault_status <= fs_next;
      fault_pc_reg <= fpc_next;
    end
  end

  // Output register: load on advance, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pa    <= pa_next;
      out_st    <= st_next;
      out_rdata <= rdata_next;
      out_sw    <= {fs_next[15:1], mmu_enable};
      out_fpc   <= fpc_next;
    end
  end

  assign physical_address = out_pa;
  assign status           = out_st;
  assign read_data        = out_rdata;
  assign status_word      = out_sw;
  assign fault_pc         = out_fpc;

endmodule

// ----- hdl/patu_checker.sv -----
// Port-level checker for the paged address translation unit.
// Uses patu_pkg status codes; bound to paged_address_translation_unit_core.
module patu_checker import patu_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [18:0] physical_address,
  input logic [2:0]  status,
  input logic [15:0] read_data,
  input logic [15:0] status_word
);

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(physical_address) && $stable(status))
    else $error("output word changed while stalled");

  // No address leaves with an abort or bus error
  a_pa_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (physical_address == 19'd0))
    else $error("physical address set on a failed access");

  // A bus error returns no register data
  a_bus_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_BUS_ERROR) |-> (read_data == 16'd0))
    else $error("read data on a bus error");

  // Aborts occur only with translation on, and are logged in the status word
  a_abort_log: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((status == ST_NON_RESIDENT) || (status == ST_LENGTH) ||
                  (status == ST_READ_ONLY))
    |-> status_word[0] && (status_word[15:13] != 3'b000))
    else $error("abort not reflected in status word");

  // Status is always a defined code
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= ST_BUS_ERROR))
    else $error("undefined status code");

endmodule

bind paged_address_translation_unit_core patu_checker u_patu_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .physical_address (physical_address),
  .status           (status),
  .read_data        (read_data),
  .status_word      (status_word)
);

// ----- tb/tb_top.sv -----
// Self-checking bench for paged_address_translation_unit_core.
// Drives directed rows and random words; typed rows give their results and
// the rest are predicted from shadow tables and fault regs; needs patu_pkg.
module tb_top;
  import patu_pkg::*;

  localparam logic SPACE_I   = 1'b0;
  localparam logic SPACE_D   = 1'b1;
  localparam logic KIND_DESC = 1'b0;
  localparam logic KIND_ADDR = 1'b1;
  localparam int   PHASE_WORDS = 325;

  typedef struct packed {
    op_t         op;
    logic [15:0] vaddr;
    logic        wr;
    logic [1:0]  md;
    logic [15:0] pc;
    logic        space;
    logic        kind;
    logic [2:0]  page;
    logic [15:0] wdata;
  } mmu_item_t;

  typedef struct packed {
    logic [18:0] pa;
    status_t     st;
    logic [15:0] rd;
    logic [15:0] sw;
    logic [15:0] fpc;
  } xlat_result_t;

  typedef struct packed {
    logic         is_cfg;
    logic         cfg_sel;
    logic [2:0]   cfg_val;
    mmu_item_t    it;
    logic         typed;
    xlat_result_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = 1'b0;
  logic [2:0]  cfg_data = 3'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  operation = 2'd0;
  logic [15:0] virtual_address = 16'd0;
  logic        is_write = 1'b0;
  logic [1:0]  mode = 2'd0;
  logic [15:0] current_pc = 16'd0;
  logic        reg_space = 1'b0;
  logic        reg_kind = 1'b0;
  logic [2:0]  reg_page = 3'd0;
  logic [15:0] write_value = 16'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [18:0] physical_address;
  logic [2:0]  status;
  logic [15:0] read_data;
  logic [15:0] status_word;
  logic [15:0] fault_pc;

  // Shadow of the unit state
  logic [15:0] descr_mem [64];
  logic [15:0] base_mem [64];
  logic [15:0] abort_status = 16'd0;
  logic [15:0] abort_pc = 16'd0;
  logic        xlat_on = 1'b0;
  logic [2:0]  dspace_sel = 3'd0;

  xlat_result_t expected_words [$];
  dir_row_t     dir_rows [$];
  int unsigned  send_idle_pct = 33;
  int unsigned  recv_idle_pct = 50;
  int           stall_reqs = 0;
  int           mismatch_count = 0;

  paged_address_translation_unit_core u_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .virtual_address(virtual_address), .is_write(is_write),
    .mode(mode), .current_pc(current_pc), .reg_space(reg_space),
    .reg_kind(reg_kind), .reg_page(reg_page), .write_value(write_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .physical_address(physical_address), .status(status), .read_data(read_data),
    .status_word(status_word), .fault_pc(fault_pc)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Record an abort in the shadow fault registers
  function automatic void latch_abort(input logic [15:0] abort_bit, input mmu_item_t it);
    abort_status = abort_bit | 16'h0001 | {12'b0, it.vaddr[15:13], 1'b0}
                   | {9'b0, it.md, 5'b0};
    abort_pc = it.pc;
  endfunction

  // Compute the result word of one accepted word and advance the shadow state
  function automatic xlat_result_t mmu_predict(input mmu_item_t it);
    xlat_result_t r;
    logic [5:0]   idx;
    logic         sp;
    logic [15:0]  pdr;
    logic [6:0]   blk;
    logic [6:0]   len;
    logic [12:0]  sum;
    r.pa = '0;
    r.st = ST_OK;
    r.rd = '0;
    if (it.op == OP_REG_READ || it.op == OP_REG_WRITE) begin
      if (it.md == MODE_ILLEGAL) begin
        r.st = ST_BUS_ERROR;
      end else begin
        idx = {it.space, it.md, it.page};
        if (it.op == OP_REG_READ) begin
          r.rd = it.kind ? base_mem[idx] : descr_mem[idx];
        end else begin
          if (it.kind) base_mem[idx] = it.wdata;
          else descr_mem[idx] = it.wdata;
          descr_mem[idx] = descr_mem[idx] & ~WRITTEN_MASK;
        end
      end
    end else if (!xlat_on) begin
      r.pa = (it.vaddr >= IO_PAGE) ? {3'b0, it.vaddr} + IO_RELOC : {3'b0, it.vaddr};
    end else begin
      // Data accesses fall back to instruction pages unless the mode has its own
      sp = 1'b0;
      if (it.op == OP_DATA) begin
        case (it.md)
          MODE_USER:       sp = dspace_sel[0];
          MODE_SUPERVISOR: sp = dspace_sel[1];
          MODE_KERNEL:     sp = dspace_sel[2];
          default:         sp = 1'b1;
        endcase
      end
      idx = {sp, it.md, it.vaddr[15:13]};
      pdr = descr_mem[idx];
      blk = it.vaddr[12:6];
      len = pdr[14:8];
      if (it.wr && pdr[2:1] != 2'b11) begin
        r.st = ST_READ_ONLY;
        latch_abort(ABORT_RD_ONLY, it);
      end else if (!pdr[1]) begin
        r.st = ST_NON_RESIDENT;
        latch_abort(ABORT_NON_RES, it);
      end else if (pdr[3] ? (blk < len) : (blk > len)) begin
        r.st = ST_LENGTH;
        latch_abort(ABORT_LENGTH, it);
      end else begin
        if (it.wr) descr_mem[idx] = pdr | WRITTEN_MASK;
        sum = {6'b0, blk} + {1'b0, base_mem[idx][11:0]};
        r.pa = {sum, it.vaddr[5:0]};
      end
    end
    r.sw = {abort_status[15:1], xlat_on};
    r.fpc = abort_pc;
    return r;
  endfunction

  function automatic dir_row_t row_item(input op_t op, input logic [15:0] va,
                                        input logic wr, input logic [1:0] md,
                                        input logic [15:0] pc, input logic sp,
                                        input logic kind, input logic [2:0] pg,
                                        input logic [15:0] wv);
    dir_row_t r;
    r = '0;
    r.it.op = op;
    r.it.vaddr = va;
    r.it.wr = wr;
    r.it.md = md;
    r.it.pc = pc;
    r.it.space = sp;
    r.it.kind = kind;
    r.it.page = pg;
    r.it.wdata = wv;
    r.want.st = ST_OK;
    return r;
  endfunction

  function automatic dir_row_t typed_row(input dir_row_t r, input logic [18:0] pa,
                                         input status_t st, input logic [15:0] rd,
                                         input logic [15:0] sw, input logic [15:0] fpc);
    dir_row_t t;
    t = r;
    t.typed = 1'b1;
    t.want.pa = pa;
    t.want.st = st;
    t.want.rd = rd;
    t.want.sw = sw;
    t.want.fpc = fpc;
    return t;
  endfunction

  function automatic dir_row_t row_cfg(input logic sel, input logic [2:0] val);
    dir_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.cfg_sel = sel;
    r.cfg_val = val;
    r.it.op = OP_FETCH;
    r.want.st = ST_OK;
    return r;
  endfunction

  function automatic mmu_item_t random_word();
    mmu_item_t it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 12) it.op = OP_REG_WRITE;
    else if (pick < 20) it.op = OP_REG_READ;
    else if (pick < 60) it.op = OP_DATA;
    else it.op = OP_FETCH;
    it.vaddr = 16'($urandom);
    it.wr = 1'($urandom_range(1));
    it.md = 2'($urandom_range(3));
    // Keep the illegal mode rarer so most register words land
    if (it.md == MODE_ILLEGAL && $urandom_range(1) == 1) it.md = MODE_USER;
    it.pc = 16'($urandom);
    it.space = 1'($urandom_range(1));
    it.kind = 1'($urandom_range(1));
    it.page = 3'($urandom_range(7));
    it.wdata = 16'($urandom);
    // Bias descriptor writes toward resident pages
    if (it.op == OP_REG_WRITE && it.kind == KIND_DESC && $urandom_range(3) != 0)
      it.wdata[2:1] = ($urandom_range(1) == 1) ? 2'b11 : 2'b01;
    return it;
  endfunction

  // Offer one word, with a random gap before it, and hold it until accepted
  task automatic send_word(input mmu_item_t it, input logic typed, input xlat_result_t want);
    int gap;
    xlat_result_t got;
    // Idle each cycle with the sender's idle share
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    operation <= it.op;
    virtual_address <= it.vaddr;
    is_write <= it.wr;
    mode <= it.md;
    current_pc <= it.pc;
    reg_space <= it.space;
    reg_kind <= it.kind;
    reg_page <= it.page;
    write_value <= it.wdata;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    got = mmu_predict(it);
    expected_words.push_back(typed ? want : got);
  endtask

  // Drop valid and wait until every expected word has come back
  task automatic drain_words();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(input logic sel, input logic [2:0] val);
    drain_words();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (sel == CFG_MMU_ENABLE) xlat_on = val[0];
    else dspace_sel = val;
  endtask

  // Receiver: random backpressure, plus a long hold-off on request
  initial begin
    int hold_left;
    int stalls_done;
    hold_left = 0;
    stalls_done = 0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (stalls_done != stall_reqs) begin
        stalls_done++;
        hold_left = 47;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic void note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endfunction

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    xlat_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        note_failure($sformatf("result word with nothing expected: pa=%h st=%0d",
                               physical_address, status));
      end else begin
        e = expected_words.pop_front();
        if (physical_address != e.pa || status != e.st || read_data != e.rd ||
            status_word != e.sw || fault_pc != e.fpc)
          note_failure($sformatf(
            "mismatch: want pa=%h st=%0d rd=%h sw=%h fpc=%h, got pa=%h st=%0d rd=%h sw=%h fpc=%h",
            e.pa, e.st, e.rd, e.sw, e.fpc,
            physical_address, status, read_data, status_word, fault_pc));
      end
    end
  end

  initial begin
    #400000;
    $display("paged_address_translation_unit_core regression: fail");
    $finish;
  end

  initial begin
    xlat_result_t none;
    logic         en_next;
    logic [2:0]   ds_next;
    none = '0;
    for (int k = 0; k < 64; k++) begin
      descr_mem[k] = 16'd0;
      base_mem[k] = 16'd0;
    end

    // Pass-through after reset, register access, bus errors, table setup
    dir_rows.push_back(typed_row(row_item(OP_FETCH, 16'o000000, 1'b0, MODE_KERNEL,
      16'h0000, SPACE_I, KIND_DESC, 3'd0, 16'h0000), 19'o0, ST_OK, 16'h0, 16'h0, 16'h0));
    dir_rows.push_back(typed_row(row_item(OP_DATA, 16'o167777, 1'b1, MODE_USER,
      16'hFFFF, SPACE_D, KIND_ADDR, 3'd7, 16'hFFFF), 19'o167777, ST_OK, 16'h0, 16'h0, 16'h0));
    dir_rows.push_back(typed_row(row_item(OP_FETCH, 16'o170000, 1'b0, MODE_SUPERVISOR,
      16'h0000, SPACE_I, KIND_DESC, 3'd0, 16'h0000), 19'o770000, ST_OK, 16'h0, 16'h0, 16'h0));
    dir_rows.push_back(typed_row(row_item(OP_DATA, 16'o177777, 1'b1, MODE_ILLEGAL,
      16'h0000, SPACE_I, KIND_DESC, 3'd0, 16'h0000), 19'o777777, ST_OK, 16'h0, 16'h0, 16'h0));
    dir_rows.push_back(typed_row(row_item(OP_REG_READ, 16'h0000, 1'b0, MODE_USER,
      16'h0000, SPACE_D, KIND_ADDR, 3'd7, 16'h0000), 19'o0, ST_OK, 16'h0, 16'h0, 16'h0));
    dir_rows.push_back(typed_row(row_item(OP_REG_WRITE, 16'hFFFF, 1'b1, MODE_ILLEGAL,
      16'hFFFF, SPACE_D, KIND_ADDR, 3'd7, 16'hFFFF), 19'o0, ST_BUS_ERROR, 16'h0, 16'h0, 16'h0));
    dir_rows.push_back(typed_row(row_item(OP_REG_READ, 16'h0000, 1'b0, MODE_ILLEGAL,
      16'h0000, SPACE_I, KIND_DESC, 3'd0, 16'h0000), 19'o0, ST_BUS_ERROR, 16'h0, 16'h0, 16'h0));
    dir_rows.push_back(typed_row(row_item(OP_REG_WRITE, 16'h0000, 1'b0, MODE_KERNEL,
      16'h0000, SPACE_I, KIND_DESC, 3'd0, 16'h7F06), 19'o0, ST_OK, 16'h0, 16'h0, 16'h0));
    dir_rows.push_back(typed_row(row_item(OP_REG_WRITE, 16'h0000, 1'b0, MODE_KERNEL,
      16'h0000, SPACE_I, KIND_ADDR, 3'd0, 16'o007777), 19'o0, ST_OK, 16'h0, 16'h0, 16'h0));
    dir_rows.push_back(row_item(OP_REG_WRITE, 16'h0000, 1'b0, MODE_USER,
      16'h0000, SPACE_I, KIND_DESC, 3'd1, 16'h100A));
    dir_rows.push_back(row_item(OP_REG_WRITE, 16'h0000, 1'b0, MODE_KERNEL,
      16'h0000, SPACE_D, KIND_DESC, 3'd7, 16'h0006));
    dir_rows.push_back(typed_row(row_item(OP_REG_READ, 16'h0000, 1'b0, MODE_KERNEL,
      16'h0000, SPACE_I, KIND_DESC, 3'd0, 16'h0000), 19'o0, ST_OK, 16'h7F06, 16'h0, 16'h0));

    // Translation on with every mode using data pages
    dir_rows.push_back(row_cfg(CFG_MMU_ENABLE, 3'd1));
    dir_rows.push_back(row_cfg(CFG_DATA_SPACE, 3'd7));
    dir_rows.push_back(typed_row(row_item(OP_FETCH, 16'o000000, 1'b0, MODE_KERNEL,
      16'h0000, SPACE_I, KIND_DESC, 3'd0, 16'h0000), 19'o777700, ST_OK, 16'h0, 16'h0001, 16'h0));
    dir_rows.push_back(row_item(OP_FETCH, 16'o017777, 1'b0, MODE_KERNEL,
      16'h0000, SPACE_I, KIND_DESC, 3'd0, 16'h0000));
    dir_rows.push_back(typed_row(row_item(OP_DATA, 16'o000000, 1'b1, MODE_KERNEL,
      16'hFFFF, SPACE_I, KIND_DESC, 3'd0, 16'h0000), 19'o0, ST_READ_ONLY, 16'h0, 16'h2001,
      16'hFFFF));
    dir_rows.push_back(row_item(OP_DATA, 16'o160000, 1'b0, MODE_KERNEL,
      16'h0100, SPACE_I, KIND_DESC, 3'd0, 16'h0000));
    dir_rows.push_back(row_item(OP_DATA, 16'o160100, 1'b0, MODE_KERNEL,
      16'h0200, SPACE_I, KIND_DESC, 3'd0, 16'h0000));
    dir_rows.push_back(row_item(OP_FETCH, 16'o020000, 1'b0, MODE_USER,
      16'h0300, SPACE_I, KIND_DESC, 3'd0, 16'h0000));
    dir_rows.push_back(row_item(OP_FETCH, 16'o024000, 1'b0, MODE_USER,
      16'h0400, SPACE_I, KIND_DESC, 3'd0, 16'h0000));
    dir_rows.push_back(row_item(OP_FETCH, 16'o024000, 1'b1, MODE_USER,
      16'h0500, SPACE_I, KIND_DESC, 3'd0, 16'h0000));
    dir_rows.push_back(typed_row(row_item(OP_DATA, 16'o040000, 1'b0, MODE_SUPERVISOR,
      16'h1234, SPACE_I, KIND_DESC, 3'd0, 16'h0000), 19'o0, ST_NON_RESIDENT, 16'h0, 16'h8025,
      16'h1234));

    // Data falls back to instruction pages; written bit set and cleared
    dir_rows.push_back(row_cfg(CFG_DATA_SPACE, 3'd0));
    dir_rows.push_back(row_item(OP_DATA, 16'o000100, 1'b1, MODE_KERNEL,
      16'h0600, SPACE_I, KIND_DESC, 3'd0, 16'h0000));
    dir_rows.push_back(row_item(OP_REG_READ, 16'h0000, 1'b0, MODE_KERNEL,
      16'h0000, SPACE_I, KIND_DESC, 3'd0, 16'h0000));
    dir_rows.push_back(row_item(OP_FETCH, 16'o000000, 1'b0, MODE_ILLEGAL,
      16'h0700, SPACE_I, KIND_DESC, 3'd0, 16'h0000));
    dir_rows.push_back(row_item(OP_REG_WRITE, 16'h0000, 1'b0, MODE_KERNEL,
      16'h0000, SPACE_I, KIND_ADDR, 3'd0, 16'h0000));
    dir_rows.push_back(row_item(OP_REG_READ, 16'h0000, 1'b0, MODE_KERNEL,
      16'h0000, SPACE_I, KIND_DESC, 3'd0, 16'h0000));

    // Hold reset, then release at a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_cfg(dir_rows[i].cfg_sel, dir_rows[i].cfg_val);
      else send_word(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random phases: new settings each phase, idling shifts every two phases
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin en_next = 1'b1; ds_next = 3'd7; end
        1: begin en_next = 1'b0; ds_next = 3'd0; end
        2: begin en_next = 1'b1; ds_next = 3'($urandom_range(7)); end
        3: begin en_next = 1'b1; ds_next = 3'd0; end
        4: begin en_next = 1'b1; ds_next = 3'($urandom_range(7)); end
        default: begin en_next = 1'b1; ds_next = 3'd5; end
      endcase
      write_cfg(CFG_MMU_ENABLE, {2'b00, en_next});
      write_cfg(CFG_DATA_SPACE, ds_next);
      if (ph < 2) begin
        send_idle_pct = 33;
        recv_idle_pct = 50;
      end else if (ph < 4) begin
        send_idle_pct = 50;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // Long receiver hold-off while words keep coming
        if (ph == 2 && n == 100) stall_reqs++;
        // Sender pause until the unit has emptied
        if (ph == 3 && n == 150) drain_words();
        send_word(random_word(), 1'b0, none);
      end
    end

    drain_words();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("paged_address_translation_unit_core regression: pass");
    end else begin
      $display("paged_address_translation_unit_core regression: fail");
    end
    $finish;
  end

endmodule
